// ===== rtl/core/capw_pkg.sv =====
// Shared types, register indexes and format constants of the clipped alpha pixel writer.
package capw_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ROWS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS = 3'd6;

  localparam logic [2:0] MODE_RGB444 = 3'd0;
  localparam logic [2:0] MODE_RGB555 = 3'd1;
  localparam logic [2:0] MODE_RGB565 = 3'd2;
  localparam logic [2:0] MODE_BGR565 = 3'd3;
  localparam logic [2:0] MODE_RGB888 = 3'd4;

  localparam logic [2:0]  RST_COLOR_MODE  = MODE_RGB565;
  localparam logic [31:0] RST_DRAW_COLOR  = 32'hFF00_0000;
  localparam logic [15:0] RST_CLIP_LEFT   = 16'd0;
  localparam logic [15:0] RST_CLIP_TOP    = 16'd0;
  localparam logic [14:0] RST_CLIP_COLS   = 15'd320;
  localparam logic [14:0] RST_CLIP_ROWS   = 15'd240;
  localparam logic [11:0] RST_LINE_PIXELS = 12'd320;

  localparam logic [31:0] MASK_444 = 32'h00F0_0F0F;
  localparam logic [31:0] MASK_555 = 32'h03E0_7C1F;
  localparam logic [31:0] MASK_565 = 32'h07E0_F81F;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [23:0]        back_pixel;
  } capw_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] pixel_index;
    logic [23:0] new_pixel;
  } capw_out_t;

  // Spread mask that leaves headroom above each channel of a 16-bit format.
  function automatic logic [31:0] spread_mask(input logic [2:0] mode);
    logic [31:0] m;
    m = MASK_565;
    if (mode == MODE_RGB444) begin
      m = MASK_444;
    end else if (mode == MODE_RGB555) begin
      m = MASK_555;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/capw_blend.sv =====
// Color conversion and alpha blend of the drawing color over one background pixel.
module capw_blend (
  input  logic [2:0]  mode,
  input  logic [31:0] draw_color,
  input  logic [23:0] back_pixel,
  output logic [23:0] new_pixel
);

  logic [7:0]  alpha8;
  logic [8:0]  alpha_p8;
  logic [8:0]  alpha_p4;
  logic [5:0]  alpha_q;
  logic [15:0] fg16;
  logic [31:0] mask;
  logic [31:0] fg_sp;
  logic [31:0] bg_sp;
  logic [31:0] diff_sp;
  logic [31:0] prod_sp;
  logic [31:0] shift_sp;
  logic [31:0] sum_sp;
  logic [15:0] pix16;
  logic [23:0] pix24;
  logic        is_444;

  assign alpha8   = draw_color[31:24];
  assign alpha_p8 = {1'b0, alpha8} + 9'd8;
  assign alpha_p4 = {1'b0, alpha8} + 9'd4;
  assign is_444   = (mode == capw_pkg::MODE_RGB444);
  assign alpha_q  = is_444 ? {1'b0, alpha_p8[8:4]} : alpha_p4[8:3];

  always_comb begin
    unique case (mode)
      capw_pkg::MODE_RGB444: fg16 = {4'b0, draw_color[23:20], draw_color[15:12], draw_color[7:4]};
      capw_pkg::MODE_RGB555: fg16 = {1'b0, draw_color[23:19], draw_color[15:11], draw_color[7:3]};
      capw_pkg::MODE_RGB565: fg16 = {draw_color[23:19], draw_color[15:10], draw_color[7:3]};
      default:               fg16 = {draw_color[7:3], draw_color[15:10], draw_color[23:19]};
    endcase
  end

  assign mask     = capw_pkg::spread_mask(mode);
  assign fg_sp    = {fg16, fg16} & mask;
  assign bg_sp    = {back_pixel[15:0], back_pixel[15:0]} & mask;
  assign diff_sp  = fg_sp - bg_sp;
  assign prod_sp  = diff_sp * {26'b0, alpha_q};
  assign shift_sp = is_444 ? (prod_sp >> 4) : (prod_sp >> 5);
  assign sum_sp   = (bg_sp + shift_sp) & mask;
  assign pix16    = sum_sp[15:0] | sum_sp[31:16];

  logic signed [8:0]  ch_diff [3];
  logic signed [17:0] ch_prod [3];
  logic [7:0]         ch_res  [3];

  for (genvar i = 0; i < 3; i++) begin : g_chan
    assign ch_diff[i] = $signed({1'b0, draw_color[8*i +: 8]}) -
                        $signed({1'b0, back_pixel[8*i +: 8]});
    assign ch_prod[i] = ch_diff[i] * $signed({1'b0, alpha8});
    // Arithmetic shift by 8 floors the quotient; only its low byte survives.
    assign ch_res[i]  = back_pixel[8*i +: 8] + ch_prod[i][15:8];
  end

  assign pix24 = (alpha8 == 8'hFF) ? draw_color[23:0] : {ch_res[2], ch_res[1], ch_res[0]};

  // Codes above BGR565 all select the 24-bit format.
  assign new_pixel = (mode > capw_pkg::MODE_BGR565) ? pix24 : {8'b0, pix16};

endmodule

// ===== rtl/core/clipped_alpha_pixel_writer.sv =====
// Top level of the clipped alpha pixel writer: registers, clip test, index and blend.
//
//   Channel  Handshake           Data
//   input    start / busy        in_data   (capw_in_t)
//   result   out_valid           out_data  (capw_out_t)
//   config   cfg_we              cfg_index, cfg_wdata
//
// A word is taken on every cycle with start high; busy is always low.
// Each input word passes through one input register,
// then the clip test, index multiply and blend, then the result register.
// The receiver cannot stall, so the pipeline never holds.
// Synchronous reset clears the valid flags and loads the register defaults.
module clipped_alpha_pixel_writer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  capw_pkg::capw_in_t                  in_data,
  output logic                                out_valid,
  output capw_pkg::capw_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [capw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [capw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [2:0]  color_mode_r;
  logic [31:0] draw_color_r;
  logic [15:0] clip_left_r;
  logic [15:0] clip_top_r;
  logic [14:0] clip_cols_r;
  logic [14:0] clip_rows_r;
  logic [11:0] line_pixels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r  <= capw_pkg::RST_COLOR_MODE;
      draw_color_r  <= capw_pkg::RST_DRAW_COLOR;
      clip_left_r   <= capw_pkg::RST_CLIP_LEFT;
      clip_top_r    <= capw_pkg::RST_CLIP_TOP;
      clip_cols_r   <= capw_pkg::RST_CLIP_COLS;
      clip_rows_r   <= capw_pkg::RST_CLIP_ROWS;
      line_pixels_r <= capw_pkg::RST_LINE_PIXELS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        capw_pkg::REG_COLOR_MODE:  color_mode_r  <= cfg_wdata[2:0];
        capw_pkg::REG_DRAW_COLOR:  draw_color_r  <= cfg_wdata[31:0];
        capw_pkg::REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata[15:0];
        capw_pkg::REG_CLIP_TOP:    clip_top_r    <= cfg_wdata[15:0];
        capw_pkg::REG_CLIP_COLS:   clip_cols_r   <= cfg_wdata[14:0];
        capw_pkg::REG_CLIP_ROWS:   clip_rows_r   <= cfg_wdata[14:0];
        capw_pkg::REG_LINE_PIXELS: line_pixels_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  logic               in_valid_r;
  capw_pkg::capw_in_t in_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_word_r <= in_data;
    end
  end

  assign busy = 1'b0;

  logic signed [16:0] pos_x_ext;
  logic signed [16:0] pos_y_ext;
  logic signed [16:0] left_ext;
  logic signed [16:0] top_ext;
  logic signed [16:0] right_edge;
  logic signed [16:0] bottom_edge;
  logic               clip_hit;
  logic [23:0]        row_base;
  logic [23:0]        index_full;
  logic [23:0]        blend_pixel;

  assign pos_x_ext   = {in_word_r.pos_x[15], in_word_r.pos_x};
  assign pos_y_ext   = {in_word_r.pos_y[15], in_word_r.pos_y};
  assign left_ext    = {clip_left_r[15], clip_left_r};
  assign top_ext     = {clip_top_r[15], clip_top_r};
  assign right_edge  = left_ext + $signed({2'b0, clip_cols_r});
  assign bottom_edge = top_ext + $signed({2'b0, clip_rows_r});

  assign clip_hit = (pos_x_ext >= left_ext) && (pos_y_ext >= top_ext) &&
                    (pos_x_ext < right_edge) && (pos_y_ext < bottom_edge);

  assign row_base   = {{8{in_word_r.pos_y[15]}}, in_word_r.pos_y} * {12'b0, line_pixels_r};
  assign index_full = row_base + {{8{in_word_r.pos_x[15]}}, in_word_r.pos_x};

  capw_blend u_blend (
    .mode       (color_mode_r),
    .draw_color (draw_color_r),
    .back_pixel (in_word_r.back_pixel),
    .new_pixel  (blend_pixel)
  );

  logic                out_valid_r;
  capw_pkg::capw_out_t out_word_nxt;
  capw_pkg::capw_out_t out_word_r;

  always_comb begin
    out_word_nxt.write_enable = clip_hit;
    out_word_nxt.pixel_index  = clip_hit ? index_full : 24'd0;
    out_word_nxt.new_pixel    = clip_hit ? blend_pixel : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

// ===== tb/clipped_alpha_pixel_writer_tb.sv =====
// Self-checking testbench for the clipped alpha pixel writer, with directed and random traffic.
`timescale 1ns / 1ps

module clipped_alpha_pixel_writer_tb;

  localparam int PIPE_DRAIN  = 4;
  localparam int STALL_LIMIT = 1000;
  localparam logic [capw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  capw_pkg::capw_in_t              in_data;
  logic                            out_valid;
  capw_pkg::capw_out_t             out_data;
  logic                            cfg_we;
  logic [capw_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [capw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  logic [2:0]         cur_mode;
  logic [31:0]        cur_color;
  logic signed [15:0] cur_left;
  logic signed [15:0] cur_top;
  logic [14:0]        cur_cols;
  logic [14:0]        cur_rows;
  logic [11:0]        cur_line;

  capw_pkg::capw_out_t pending_writes[$];
  int                  error_count;
  int                  stall_cycles;
  bit                  gaps_on;

  clipped_alpha_pixel_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] pack_16bit(logic [2:0] mode, logic [31:0] c);
    case (mode)
      capw_pkg::MODE_RGB444: return {4'h0, c[23:20], c[15:12], c[7:4]};
      capw_pkg::MODE_RGB555: return {1'b0, c[23:19], c[15:11], c[7:3]};
      capw_pkg::MODE_RGB565: return {c[23:19], c[15:10], c[7:3]};
      default:               return {c[7:3], c[15:10], c[23:19]};
    endcase
  endfunction

  function automatic logic [15:0] blend_16bit(logic [15:0] back);
    logic [31:0] mask;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [31:0] alpha;
    int          shift;
    case (cur_mode)
      capw_pkg::MODE_RGB444: mask = capw_pkg::MASK_444;
      capw_pkg::MODE_RGB555: mask = capw_pkg::MASK_555;
      default:               mask = capw_pkg::MASK_565;
    endcase
    if (cur_mode == capw_pkg::MODE_RGB444) begin
      alpha = (32'(cur_color[31:24]) + 32'd8) >> 4;
      shift = 4;
    end else begin
      alpha = (32'(cur_color[31:24]) + 32'd4) >> 3;
      shift = 5;
    end
    fg = {16'h0, pack_16bit(cur_mode, cur_color)};
    bg = {16'h0, back};
    fg = (fg | (fg << 16)) & mask;
    bg = (bg | (bg << 16)) & mask;
    bg = bg + (((fg - bg) * alpha) >> shift);
    bg = bg & mask;
    return bg[15:0] | bg[31:16];
  endfunction

  function automatic logic [23:0] blend_24bit(logic [23:0] back);
    logic [23:0] r;
    int          a;
    int          f;
    int          b;
    int          prod;
    a = cur_color[31:24];
    if (a == 255) begin
      return cur_color[23:0];
    end
    for (int s = 0; s < 24; s += 8) begin
      f = cur_color[s +: 8];
      b = back[s +: 8];
      prod = (f - b) * a;
      r[s +: 8] = 8'(b + (prod >>> 8));
    end
    return r;
  endfunction

  function automatic capw_pkg::capw_out_t predict_pixel_write(capw_pkg::capw_in_t w);
    capw_pkg::capw_out_t r;
    int                  x;
    int                  y;
    int                  l;
    int                  t;
    r = '0;
    x = $signed(w.pos_x);
    y = $signed(w.pos_y);
    l = cur_left;
    t = cur_top;
    if (x >= l && y >= t && x < l + int'(cur_cols) && y < t + int'(cur_rows)) begin
      r.write_enable = 1'b1;
      r.pixel_index = 24'(y * int'(cur_line) + x);
      if (cur_mode <= capw_pkg::MODE_BGR565) begin
        r.new_pixel = {8'h0, blend_16bit(w.back_pixel[15:0])};
      end else begin
        r.new_pixel = blend_24bit(w.back_pixel);
      end
    end
    return r;
  endfunction

  function automatic capw_pkg::capw_in_t make_word(int x, int y, logic [23:0] back);
    capw_pkg::capw_in_t w;
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    w.back_pixel = back;
    return w;
  endfunction

  task automatic send_pixel(input capw_pkg::capw_in_t w);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_writes.push_back(predict_pixel_write(w));
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [capw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [capw_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      capw_pkg::REG_COLOR_MODE:  cur_mode = data[2:0];
      capw_pkg::REG_DRAW_COLOR:  cur_color = data;
      capw_pkg::REG_CLIP_LEFT:   cur_left = data[15:0];
      capw_pkg::REG_CLIP_TOP:    cur_top = data[15:0];
      capw_pkg::REG_CLIP_COLS:   cur_cols = data[14:0];
      capw_pkg::REG_CLIP_ROWS:   cur_rows = data[14:0];
      capw_pkg::REG_LINE_PIXELS: cur_line = data[11:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] with_noise(int value, int bits);
    logic [31:0] d;
    d = $urandom();
    for (int i = 0; i < bits; i++) begin
      d[i] = value[i];
    end
    return d;
  endfunction

  task automatic randomize_settings();
    logic [31:0] color;
    int          edge_pos;
    int          span;
    if ($urandom_range(0, 9) < 8) begin
      write_reg(capw_pkg::REG_COLOR_MODE, with_noise($urandom_range(0, 4), 3));
    end else begin
      write_reg(capw_pkg::REG_COLOR_MODE, with_noise($urandom_range(5, 7), 3));
    end
    color = $urandom();
    case ($urandom_range(0, 3))
      0: color[31:24] = 8'h00;
      1: color[31:24] = 8'hFF;
      default: ;
    endcase
    write_reg(capw_pkg::REG_DRAW_COLOR, color);
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 5))
        0: edge_pos = -32768;
        1: edge_pos = 32767;
        default: edge_pos = int'($urandom_range(0, 800)) - 400;
      endcase
      case ($urandom_range(0, 7))
        0: span = 0;
        1: span = 32767;
        default: span = $urandom_range(1, 400);
      endcase
      write_reg(k == 0 ? capw_pkg::REG_CLIP_LEFT : capw_pkg::REG_CLIP_TOP,
                with_noise(edge_pos, 16));
      write_reg(k == 0 ? capw_pkg::REG_CLIP_COLS : capw_pkg::REG_CLIP_ROWS,
                with_noise(span, 15));
    end
    case ($urandom_range(0, 5))
      0: write_reg(capw_pkg::REG_LINE_PIXELS, with_noise(0, 12));
      1: write_reg(capw_pkg::REG_LINE_PIXELS, with_noise(4095, 12));
      default: write_reg(capw_pkg::REG_LINE_PIXELS, $urandom());
    endcase
    write_reg(REG_UNUSED, $urandom());
  endtask

  function automatic capw_pkg::capw_in_t random_word();
    int x;
    int y;
    if ($urandom_range(0, 99) < 80) begin
      x = int'(cur_left) - 4 + int'($urandom_range(0, int'(cur_cols) + 8));
      y = int'(cur_top) - 4 + int'($urandom_range(0, int'(cur_rows) + 8));
    end else begin
      x = $urandom();
      y = $urandom();
    end
    return make_word(x, y, 24'($urandom()));
  endfunction

  task automatic test_reset_values();
    send_pixel(make_word(0, 0, 24'h000000));
    send_pixel(make_word(319, 239, 24'hFFFFFF));
    send_pixel(make_word(320, 0, 24'h123456));
    send_pixel(make_word(0, 240, 24'h00FFFF));
    send_pixel(make_word(-32768, 32767, 24'hFFFFFF));
    send_pixel(make_word(32767, -32768, 24'h000000));
    settle();
  endtask

  task automatic test_pixel_formats();
    write_reg(capw_pkg::REG_DRAW_COLOR, 32'h80C0_A050);
    for (int m = 0; m < 8; m++) begin
      write_reg(capw_pkg::REG_COLOR_MODE, 32'(m));
      send_pixel(make_word(m * 7, m * 3, 24'h3C_F00F ^ 24'(m * 24'h11_1111)));
      settle();
    end
    write_reg(capw_pkg::REG_COLOR_MODE, capw_pkg::MODE_RGB888);
    write_reg(capw_pkg::REG_DRAW_COLOR, 32'hFF12_34AB);
    send_pixel(make_word(5, 5, 24'hFFFFFF));
    settle();
    write_reg(capw_pkg::REG_DRAW_COLOR, 32'h00FF_FFFF);
    send_pixel(make_word(6, 6, 24'h000000));
    settle();
    write_reg(capw_pkg::REG_COLOR_MODE, capw_pkg::MODE_RGB444);
    send_pixel(make_word(7, 7, 24'hFFFFFF));
    settle();
    write_reg(capw_pkg::REG_DRAW_COLOR, 32'hFFFF_FFFF);
    send_pixel(make_word(8, 8, 24'h000000));
    settle();
  endtask

  task automatic test_clip_extremes();
    write_reg(capw_pkg::REG_COLOR_MODE, capw_pkg::MODE_RGB565);
    write_reg(capw_pkg::REG_DRAW_COLOR, 32'h7F80_40C0);
    write_reg(capw_pkg::REG_CLIP_LEFT, 32'h0000_8000);
    write_reg(capw_pkg::REG_CLIP_TOP, 32'hFFFF_8000);
    write_reg(capw_pkg::REG_CLIP_COLS, 32'h0000_7FFF);
    write_reg(capw_pkg::REG_CLIP_ROWS, 32'hFFFF_7FFF);
    write_reg(capw_pkg::REG_LINE_PIXELS, 32'h0000_0FFF);
    send_pixel(make_word(-32768, -32768, 24'hABCDEF));
    send_pixel(make_word(-2, -2, 24'h00FFFF));
    send_pixel(make_word(-1, -2, 24'h00FFFF));
    settle();
    write_reg(capw_pkg::REG_CLIP_LEFT, 32'h0000_7FFF);
    write_reg(capw_pkg::REG_CLIP_TOP, 32'h0000_0000);
    write_reg(capw_pkg::REG_LINE_PIXELS, 32'h0000_0000);
    send_pixel(make_word(32767, 100, 24'h5A5A5A));
    settle();
    write_reg(capw_pkg::REG_CLIP_LEFT, 32'h0000_0000);
    write_reg(capw_pkg::REG_CLIP_COLS, 32'h0000_0000);
    send_pixel(make_word(0, 0, 24'h000000));
    settle();
    write_reg(capw_pkg::REG_CLIP_COLS, 32'h0000_0010);
    write_reg(capw_pkg::REG_CLIP_ROWS, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pixel(make_word(0, 0, 24'hFFFFFF));
    settle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase <= 10; phase++) begin
      settle();
      randomize_settings();
      gaps_on = (phase != 0);
      repeat (phase == 0 ? 150 : 50) begin
        maybe_gap();
        send_pixel(random_word());
      end
    end
    gaps_on = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    capw_pkg::capw_out_t want;
    if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected result word: %h", out_data);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_data.write_enable !== want.write_enable) begin
          $error("write_enable: expected %0d, actual %0d",
                 want.write_enable, out_data.write_enable);
          error_count++;
        end
        if (out_data.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %h, actual %h", want.pixel_index, out_data.pixel_index);
          error_count++;
        end
        if (out_data.new_pixel !== want.new_pixel) begin
          $error("new_pixel: expected %h, actual %h", want.new_pixel, out_data.new_pixel);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    error_count = 0;
    stall_cycles = 0;
    gaps_on = 1'b0;
    cur_mode = capw_pkg::RST_COLOR_MODE;
    cur_color = capw_pkg::RST_DRAW_COLOR;
    cur_left = capw_pkg::RST_CLIP_LEFT;
    cur_top = capw_pkg::RST_CLIP_TOP;
    cur_cols = capw_pkg::RST_CLIP_COLS;
    cur_rows = capw_pkg::RST_CLIP_ROWS;
    cur_line = capw_pkg::RST_LINE_PIXELS;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_pixel_formats();
    test_clip_extremes();
    test_random_traffic();
    settle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/capw_pkg.sv
rtl/core/capw_blend.sv
rtl/core/clipped_alpha_pixel_writer.sv
tb/clipped_alpha_pixel_writer_tb.sv
